FILE: src/pipp_pkg.sv
// Shared types and constants for the palette index pack and pad block.
`default_nettype none
package pipp_pkg;

  localparam int unsigned CFG_W    = 7;  // width of every configuration register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COLCNT_W = 6;  // holds a column count up to 32 inclusive
  localparam int unsigned ROWCNT_W = 7;  // holds a row count up to 64 inclusive
  localparam logic [7:0]  FILL_MUL = 8'h11;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_HEIGHT = 2'd3;

  localparam logic FUNC_PAIR = 1'b0;
  localparam logic FUNC_PAD  = 1'b1;

  // One unit of work handed from front to back
  typedef struct packed {
    logic                is_pad;
    logic [7:0]          data;       // packed pair byte
    logic [COLCNT_W-1:0] col;        // store column of the pair byte
    logic                fill;       // horizontal fill follows the pair byte
    logic [7:0]          fill_byte;
    logic [COLCNT_W-1:0] row_end;    // padded row length in bytes
    logic                done;       // final byte of this command ends the block
  } pipp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pipp_q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAIR,
    BK_FILL,
    BK_PAD_RD,
    BK_PAD_OUT
  } pipp_bk_state_t;

endpackage
`default_nettype wire

FILE: src/pipp_ifs.sv
// Channel interfaces: input items, result bytes and configuration writes.
`default_nettype none
interface pipp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] index_even;
  logic [3:0] index_odd;
  modport source (output valid, func, index_even, index_odd, input ready);
  modport sink   (input valid, func, index_even, index_odd, output ready);
endinterface

interface pipp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       last_in_run;
  logic       block_done;
  modport source (output valid, packed_byte, last_in_run, block_done, input ready);
  modport sink   (input valid, packed_byte, last_in_run, block_done, output ready);
endinterface

interface pipp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/palette_index_pack_pad.sv
// Top level of the palette index pack and pad block.
// Packs palette index pairs into bytes (odd index in the high nibble), fills each
// padded row with the row's last index times 0x11 and replays the last row on each
// padding request until the block height is reached. Configuration is taken at any
// time through cfg_chan but must only change while the block is idle. A front end
// accepts one item a cycle, while the queue is not full, into a two-entry command
// queue; the back end sets the pace and pops a command only when idle, then takes a
// visible pair through the pair state, each horizontal fill byte through the fill
// state and each replayed byte of a padding row through a line store read, then the
// output register. A padding request with no row owed is absorbed without a result.
`default_nettype none
module palette_index_pack_pad
  import pipp_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_SIZE = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pipp_in_if.sink    in_chan,
  pipp_out_if.source out_chan,
  pipp_cfg_if.sink   cfg_chan
);

  pipp_cmd_t    push_cmd, q_cmd;
  pipp_q_stat_t q_stat;
  logic         push, pop;

  pipp_front #(.MAX_BLOCK_SIZE(MAX_BLOCK_SIZE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pipp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .stat     (q_stat)
  );

  pipp_back #(.MAX_BLOCK_SIZE(MAX_BLOCK_SIZE)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

FILE: src/pipp_front.sv
// Front end: configuration registers, row and column tracking, command build.
`default_nettype none
module pipp_front
  import pipp_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_SIZE = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pipp_in_if.sink     in_chan,
  pipp_cfg_if.sink    cfg_chan,
  input  wire pipp_q_stat_t q_stat,
  output logic        push,
  output pipp_cmd_t   push_cmd
);

  localparam logic [CFG_W-1:0] MAX_C  = CFG_W'(MAX_BLOCK_SIZE);
  localparam logic [CFG_W-1:0] HALF_C = CFG_W'(MAX_BLOCK_SIZE / 2);

  logic [CFG_W-1:0] bw_r, bh_r, vw_r, vh_r;
  logic [COLCNT_W-1:0] pair_column_r, pair_column_nxt;
  logic [ROWCNT_W-1:0] vis_row_r, vis_row_nxt;
  logic [ROWCNT_W-1:0] pad_left_r, pad_left_nxt;

  logic [CFG_W-1:0] vw_half, bw_half, ppr_c, bp_c, vrows_c, brows_c;
  logic [COLCNT_W-1:0] ppr, bp, col_inc;
  logic [ROWCNT_W-1:0] vis_inc, pad_new, pad_dec;
  logic accept, row_end, vis_end;
  logic [7:0] pair_byte, fill_byte;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= MAX_C;
      bh_r <= MAX_C;
      vw_r <= MAX_C;
      vh_r <= MAX_C;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_BLOCK_WIDTH:    bw_r <= cfg_chan.data;
        CFG_BLOCK_HEIGHT:   bh_r <= cfg_chan.data;
        CFG_VISIBLE_WIDTH:  vw_r <= cfg_chan.data;
        CFG_VISIBLE_HEIGHT: vh_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Register sanitising: clamp to the legal ranges
  always_comb begin
    vw_half = {1'b0, vw_r[CFG_W-1:1]};
    bw_half = {1'b0, bw_r[CFG_W-1:1]};
    if (vw_half == '0)        ppr_c = CFG_W'(1);
    else if (vw_half > HALF_C) ppr_c = HALF_C;
    else                      ppr_c = vw_half;
    bp_c = (bw_half > HALF_C) ? HALF_C : bw_half;
    if (bp_c < ppr_c) bp_c = ppr_c;
    if (vh_r == '0)          vrows_c = CFG_W'(1);
    else if (vh_r > MAX_C)   vrows_c = MAX_C;
    else                     vrows_c = vh_r;
    brows_c = (bh_r > MAX_C) ? MAX_C : bh_r;
    if (brows_c < vrows_c) brows_c = vrows_c;
  end

  assign ppr       = ppr_c[COLCNT_W-1:0];
  assign bp        = bp_c[COLCNT_W-1:0];
  assign col_inc   = pair_column_r + COLCNT_W'(1);
  assign vis_inc   = vis_row_r + ROWCNT_W'(1);
  assign row_end   = (col_inc >= ppr);
  assign vis_end   = row_end && (vis_inc >= ROWCNT_W'(vrows_c));
  assign pad_new   = ROWCNT_W'(brows_c - vrows_c);
  assign pad_dec   = pad_left_r - ROWCNT_W'(1);
  assign pair_byte = {in_chan.index_odd, in_chan.index_even};
  assign fill_byte = {in_chan.index_odd, in_chan.index_odd};

  assign in_chan.ready = !q_stat.full;
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    pair_column_nxt = pair_column_r;
    vis_row_nxt     = vis_row_r;
    pad_left_nxt    = pad_left_r;
    push            = 1'b0;
    push_cmd        = '0;
    push_cmd.row_end = bp;
    if (accept) begin
      if (in_chan.func == FUNC_PAD) begin
        // a request with no row owed is dropped
        if (pad_left_r != '0) begin
          push          = 1'b1;
          push_cmd.is_pad = 1'b1;
          push_cmd.done = (pad_dec == '0);
          pad_left_nxt  = pad_dec;
        end
      end else begin
        push               = 1'b1;
        push_cmd.data      = pair_byte;
        push_cmd.col       = pair_column_r;
        push_cmd.fill      = row_end && (col_inc < bp);
        push_cmd.fill_byte = fill_byte;
        push_cmd.done      = vis_end && (pad_new == '0);
        pad_left_nxt       = vis_end ? pad_new : '0;
        pair_column_nxt    = row_end ? '0 : col_inc;
        if (row_end) vis_row_nxt = vis_end ? '0 : vis_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_column_r <= '0;
      vis_row_r     <= '0;
      pad_left_r    <= '0;
    end else begin
      pair_column_r <= pair_column_nxt;
      vis_row_r     <= vis_row_nxt;
      pad_left_r    <= pad_left_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/pipp_queue.sv
// Two-entry command queue between front and back.
`default_nettype none
module pipp_queue
  import pipp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire pipp_cmd_t push_cmd,
  input  wire logic  pop,
  output pipp_cmd_t  pop_cmd,
  output pipp_q_stat_t stat
);

  pipp_cmd_t  slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign pop_cmd    = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/pipp_back.sv
// Back end: line store, fill and replay sequencer, output register.
`default_nettype none
module pipp_back
  import pipp_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_SIZE = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire pipp_q_stat_t q_stat,
  input  wire pipp_cmd_t    q_cmd,
  output logic         pop,
  pipp_out_if.source   out_chan
);

  localparam int unsigned DEPTH  = MAX_BLOCK_SIZE / 2;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pipp_bk_state_t state_r, state_nxt;
  pipp_cmd_t      cmd_r, cmd_nxt;
  logic [COLCNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_done_r, out_done_nxt;
  logic       load, can_load, run_last;

  assign can_load = !out_valid_r || out_chan.ready;
  assign cnt_inc  = cnt_r + COLCNT_W'(1);
  assign run_last = (cnt_inc == cmd_r.row_end);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:    if (!q_stat.empty) state_nxt = q_cmd.is_pad ? BK_PAD_RD : BK_PAIR;
      BK_PAIR:    if (can_load) state_nxt = cmd_r.fill ? BK_FILL : BK_IDLE;
      BK_FILL:    if (can_load && run_last) state_nxt = BK_IDLE;
      BK_PAD_RD:  state_nxt = BK_PAD_OUT;
      BK_PAD_OUT: if (can_load) state_nxt = run_last ? BK_IDLE : BK_PAD_RD;
      default:    state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    load         = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;
    wr_en        = 1'b0;
    wr_addr      = cnt_r[ADDR_W-1:0];
    wr_data      = cmd_r.fill_byte;
    rd_en        = 1'b0;
    rd_addr      = cnt_r[ADDR_W-1:0];
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = q_cmd;
          cnt_nxt = q_cmd.is_pad ? '0 : q_cmd.col + COLCNT_W'(1);
        end
      end
      BK_PAIR: begin
        if (can_load) begin
          load         = 1'b1;
          out_byte_nxt = cmd_r.data;
          out_last_nxt = !cmd_r.fill;
          out_done_nxt = cmd_r.done && !cmd_r.fill;
          wr_en        = 1'b1;
          wr_addr      = cmd_r.col[ADDR_W-1:0];
          wr_data      = cmd_r.data;
        end
      end
      BK_FILL: begin
        if (can_load) begin
          load         = 1'b1;
          out_byte_nxt = cmd_r.fill_byte;
          out_last_nxt = run_last;
          out_done_nxt = run_last && cmd_r.done;
          wr_en        = 1'b1;
          cnt_nxt      = cnt_inc;
        end
      end
      BK_PAD_RD: rd_en = 1'b1;
      BK_PAD_OUT: begin
        if (can_load) begin
          load         = 1'b1;
          out_byte_nxt = rd_data_r;
          out_last_nxt = run_last;
          out_done_nxt = run_last && cmd_r.done;
          cnt_nxt      = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    cnt_r <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load)                out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.packed_byte = out_byte_r;
  assign out_chan.last_in_run = out_last_r;
  assign out_chan.block_done  = out_done_r;

endmodule
`default_nettype wire

FILE: src/pipp_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module pipp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last,
  input wire logic       out_done
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transfer");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last) && $stable(out_done))
    else $error("stalled result changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last)
    else $error("block end flagged on a byte that does not close its run");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind palette_index_pack_pad pipp_checker u_pipp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.packed_byte),
  .out_last  (out_chan.last_in_run),
  .out_done  (out_chan.block_done)
);
`default_nettype wire
